// ===== hdl/law_pkg.sv =====
// Package for the lattice aggregation walker: field widths, command and
// status codes, register indexes, reset values and the controller state type.
// No dependencies.
`default_nettype none

package law_pkg;

  localparam int CMD_W      = 1;
  localparam int IN_COORD_W = 8;
  localparam int STEP_W     = 5;
  localparam int STATUS_W   = 4;
  localparam int SIZE_W     = 10;
  localparam int BOUND_W    = 7;
  localparam int STEPS_W    = 10;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_STARTED    = 4'd0,
    ST_REJECTED   = 4'd1,
    ST_MOVED      = 4'd2,
    ST_OUT_BOUNDS = 4'd3,
    ST_AGGREGATED = 4'd4,
    ST_NEAR_MISS  = 4'd5,
    ST_BUDGET     = 4'd6,
    ST_FULL       = 4'd7,
    ST_NO_WALKER  = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    REG_BOUND_X      = 3'd0,
    REG_BOUND_Y      = 3'd1,
    REG_START_EDGE_X = 3'd2,
    REG_START_EDGE_Y = 3'd3,
    REG_MAX_STEPS    = 3'd4
  } reg_idx_t;

  localparam logic [BOUND_W-1:0] RST_BOUND      = 7'd20;
  localparam logic [BOUND_W-1:0] RST_START_EDGE = 7'd14;
  localparam logic [STEPS_W-1:0] RST_MAX_STEPS  = 10'd600;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SEARCH
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/law_if.sv =====
// Valid/ready channel interfaces for the lattice aggregation walker:
// command words in, result words out. Depends on law_pkg.
`default_nettype none

interface law_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [law_pkg::CMD_W-1:0]                 cmd;
  logic signed [law_pkg::IN_COORD_W-1:0]     start_x;
  logic signed [law_pkg::IN_COORD_W-1:0]     start_y;
  logic signed [law_pkg::STEP_W-1:0]         step_x;
  logic signed [law_pkg::STEP_W-1:0]         step_y;

  modport source (output valid, cmd, start_x, start_y, step_x, step_y, input ready);
  modport sink   (input valid, cmd, start_x, start_y, step_x, step_y, output ready);
endinterface

interface law_out_if;
  logic                                      valid;
  logic                                      ready;
  logic [law_pkg::STATUS_W-1:0]              status;
  logic signed [law_pkg::IN_COORD_W-1:0]     pos_x;
  logic signed [law_pkg::IN_COORD_W-1:0]     pos_y;
  logic [law_pkg::SIZE_W-1:0]                cluster_size;

  modport source (output valid, status, pos_x, pos_y, cluster_size, input ready);
  modport sink   (input valid, status, pos_x, pos_y, cluster_size, output ready);
endinterface

`default_nettype wire

// ===== hdl/lattice_aggregation_walker_unit.sv =====
// Lattice aggregation walker: one walker on a square lattice, a cluster of
// points held in a RAM that is scanned on in-bounds steps.
// Depends on law_pkg, law_if (law_in_if, law_out_if) and law_ram.
//
// Usage:
//   in_ch carries command words: a start (cmd 0) places a walker, a step
//   (cmd 1) adds step_x/step_y to it. Each command word yields exactly one
//   result word on out_ch: status, position and cluster size afterwards.
//   Registers bound_x, bound_y, start_edge_x, start_edge_y and max_steps
//   sit on the APB port at byte addresses 0, 4, 8, 12, 16; write them only
//   while the block is idle.
// Timing:
//   A start, a step with no walker or a step that leaves the bounds is
//   accepted in S_IDLE and evaluated in S_EVAL. Any other step scans the
//   cluster RAM one entry per cycle through its single read port (entry 0,
//   the origin, is checked without a read) unless it lands on the origin or
//   the cluster holds only the origin. The result word appears the cycle
//   after evaluation ends; one item is in work at a time.
// Reset: registers return to their defaults, the cluster holds only the
//   origin and no walker is live. No RAM clearing pass is needed.
// Stall: the result sits in an output register; the next command word is
//   accepted meanwhile, and its result waits while that register is full.
`default_nettype none

module lattice_aggregation_walker_unit #(
  parameter int CLUSTER_DEPTH = 512,
  parameter int COORD_BITS    = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [law_pkg::APB_AW-1:0]   paddr,
  input  wire logic [law_pkg::APB_DW-1:0]   pwdata,
  output logic      [law_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  law_in_if.sink                            in_ch,
  law_out_if.source                         out_ch
);

  localparam int AW    = $clog2(CLUSTER_DEPTH);
  localparam int CNT_W = $clog2(CLUSTER_DEPTH + 1);
  localparam int WW    = ((COORD_BITS > law_pkg::IN_COORD_W) ? COORD_BITS
                                                             : law_pkg::IN_COORD_W) + 2;
  localparam int CB    = COORD_BITS;
  localparam int ICW   = law_pkg::IN_COORD_W;

  // configuration
  logic [law_pkg::BOUND_W-1:0] bound_x, bound_y, start_edge_x, start_edge_y;
  logic [law_pkg::STEPS_W-1:0] max_steps;

  // state
  law_pkg::state_t   state, state_next;
  logic signed [CB-1:0] walker_px, walker_py;
  logic [law_pkg::STEPS_W-1:0] steps_taken;
  logic              walker_live;
  logic [CNT_W-1:0]  cluster_count;
  logic [CNT_W-1:0]  iss;

  // latched command
  logic                         lat_cmd;
  logic signed [ICW-1:0]        lat_sx, lat_sy;
  logic signed [law_pkg::STEP_W-1:0] lat_dx, lat_dy;

  // output register
  logic                 out_valid;
  law_pkg::status_t     out_status;
  logic [ICW-1:0]       out_x, out_y;
  logic [law_pkg::SIZE_W-1:0] out_size;

  // RAM
  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  logic [2*CB-1:0]     ram_rd_data;

  // ---------------- APB ----------------
  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      law_pkg::REG_BOUND_X:      prdata = law_pkg::APB_DW'(bound_x);
      law_pkg::REG_BOUND_Y:      prdata = law_pkg::APB_DW'(bound_y);
      law_pkg::REG_START_EDGE_X: prdata = law_pkg::APB_DW'(start_edge_x);
      law_pkg::REG_START_EDGE_Y: prdata = law_pkg::APB_DW'(start_edge_y);
      law_pkg::REG_MAX_STEPS:    prdata = law_pkg::APB_DW'(max_steps);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  logic signed [WW-1:0] sx_ext, sy_ext, px_ext, py_ext, nx_w, ny_w;
  logic signed [WW-1:0] cx_ext, cy_ext, ddx, ddy;
  logic [WW-1:0]        asx, asy, anx, any_, adx, ady;
  logic signed [CB-1:0] cand_x, cand_y;
  logic                 start_ok, oob, imm, origin_hit, single, ram_hit;
  logic                 resolve, hit, d_one, out_free, commit, go_search;
  logic [law_pkg::STEPS_W:0] steps_inc;

  law_pkg::status_t     res_status;
  logic signed [WW-1:0] res_x, res_y;
  logic signed [CB-1:0] px_n, py_n;
  logic                 live_n;
  logic [law_pkg::STEPS_W-1:0] steps_n;
  logic [CNT_W-1:0]     count_n;
  logic [15:0]          count_wide;

  always_comb begin
    sx_ext = {{(WW-ICW){lat_sx[ICW-1]}}, lat_sx};
    sy_ext = {{(WW-ICW){lat_sy[ICW-1]}}, lat_sy};
    px_ext = {{(WW-CB){walker_px[CB-1]}}, walker_px};
    py_ext = {{(WW-CB){walker_py[CB-1]}}, walker_py};
    nx_w   = px_ext + {{(WW-law_pkg::STEP_W){lat_dx[law_pkg::STEP_W-1]}}, lat_dx};
    ny_w   = py_ext + {{(WW-law_pkg::STEP_W){lat_dy[law_pkg::STEP_W-1]}}, lat_dy};
    asx    = sx_ext[WW-1] ? WW'(-sx_ext) : WW'(sx_ext);
    asy    = sy_ext[WW-1] ? WW'(-sy_ext) : WW'(sy_ext);
    anx    = nx_w[WW-1] ? WW'(-nx_w) : WW'(nx_w);
    any_   = ny_w[WW-1] ? WW'(-ny_w) : WW'(ny_w);
    cand_x = nx_w[CB-1:0];
    cand_y = ny_w[CB-1:0];
    cx_ext = {{(WW-CB){cand_x[CB-1]}}, cand_x};
    cy_ext = {{(WW-CB){cand_y[CB-1]}}, cand_y};
    ddx    = cx_ext - px_ext;
    ddy    = cy_ext - py_ext;
    adx    = ddx[WW-1] ? WW'(-ddx) : WW'(ddx);
    ady    = ddy[WW-1] ? WW'(-ddy) : WW'(ddy);
    d_one  = ((WW+1)'(adx) + (WW+1)'(ady)) == (WW+1)'(1);

    start_ok   = (asx >= WW'(start_edge_x)) && (asy >= WW'(start_edge_y));
    oob        = (anx > WW'(bound_x)) || (any_ > WW'(bound_y));
    imm        = (lat_cmd == law_pkg::CMD_START) || !walker_live || oob;
    origin_hit = (cand_x == '0) && (cand_y == '0);
    single     = (cluster_count == CNT_W'(1));
    ram_hit    = (ram_rd_data == {cand_x, cand_y});
    go_search  = (state == law_pkg::S_EVAL) && !imm && !origin_hit && !single;

    resolve = ((state == law_pkg::S_EVAL) && (imm || origin_hit || single)) ||
              ((state == law_pkg::S_SEARCH) && (ram_hit || (iss == cluster_count)));
    hit      = (state == law_pkg::S_EVAL) ? origin_hit : ram_hit;
    out_free = !out_valid || out_ch.ready;
    commit   = resolve && out_free;
    steps_inc = (law_pkg::STEPS_W+1)'(steps_taken) + (law_pkg::STEPS_W+1)'(1);

    res_status = law_pkg::ST_MOVED;
    res_x      = '0;
    res_y      = '0;
    px_n       = walker_px;
    py_n       = walker_py;
    live_n     = walker_live;
    steps_n    = steps_taken;
    count_n    = cluster_count;
    ram_wr_en  = 1'b0;

    if (lat_cmd == law_pkg::CMD_START) begin
      res_x  = sx_ext;
      res_y  = sy_ext;
      if (start_ok) begin
        res_status = law_pkg::ST_STARTED;
        px_n       = sx_ext[CB-1:0];
        py_n       = sy_ext[CB-1:0];
        steps_n    = '0;
        live_n     = 1'b1;
      end else begin
        res_status = law_pkg::ST_REJECTED;
        live_n     = 1'b0;
      end
    end else if (!walker_live) begin
      res_status = law_pkg::ST_NO_WALKER;
    end else if (oob) begin
      res_status = law_pkg::ST_OUT_BOUNDS;
      live_n     = 1'b0;
      res_x      = px_ext;
      res_y      = py_ext;
    end else begin
      steps_n = steps_inc[law_pkg::STEPS_W-1:0];
      if (hit) begin
        live_n = 1'b0;
        if (d_one) begin
          res_x = px_ext;
          res_y = py_ext;
          if (cluster_count < CNT_W'(CLUSTER_DEPTH)) begin
            res_status = law_pkg::ST_AGGREGATED;
            count_n    = cluster_count + CNT_W'(1);
            ram_wr_en  = commit;
          end else begin
            res_status = law_pkg::ST_FULL;
          end
        end else begin
          res_status = law_pkg::ST_NEAR_MISS;
          res_x      = cx_ext;
          res_y      = cy_ext;
        end
      end else begin
        px_n  = cand_x;
        py_n  = cand_y;
        res_x = cx_ext;
        res_y = cy_ext;
        if (steps_inc >= (law_pkg::STEPS_W+1)'(max_steps)) begin
          res_status = law_pkg::ST_BUDGET;
          live_n     = 1'b0;
        end else begin
          res_status = law_pkg::ST_MOVED;
        end
      end
    end
    count_wide = 16'(count_n);
  end

  law_ram #(
    .WIDTH (2*CB),
    .DEPTH (CLUSTER_DEPTH)
  ) u_cluster_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (cluster_count[AW-1:0]),
    .wr_data ({walker_px, walker_py}),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // ---------------- control ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      law_pkg::S_IDLE: begin
        if (in_ch.valid) state_next = law_pkg::S_EVAL;
      end
      law_pkg::S_EVAL: begin
        if (commit) state_next = law_pkg::S_IDLE;
        else if (go_search) state_next = law_pkg::S_SEARCH;
      end
      law_pkg::S_SEARCH: begin
        if (commit) state_next = law_pkg::S_IDLE;
      end
      default: state_next = law_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == law_pkg::S_IDLE);
    ram_rd_en   = go_search || ((state == law_pkg::S_SEARCH) && !resolve);
    ram_rd_addr = (state == law_pkg::S_EVAL) ? AW'(1) : iss[AW-1:0];
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.pos_x        = out_x;
  assign out_ch.pos_y        = out_y;
  assign out_ch.cluster_size = out_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= law_pkg::S_IDLE;
      bound_x       <= law_pkg::RST_BOUND;
      bound_y       <= law_pkg::RST_BOUND;
      start_edge_x  <= law_pkg::RST_START_EDGE;
      start_edge_y  <= law_pkg::RST_START_EDGE;
      max_steps     <= law_pkg::RST_MAX_STEPS;
      walker_px     <= '0;
      walker_py     <= '0;
      steps_taken   <= '0;
      walker_live   <= 1'b0;
      cluster_count <= CNT_W'(1);
      iss           <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        unique case (cfg_idx)
          law_pkg::REG_BOUND_X:      bound_x      <= pwdata[law_pkg::BOUND_W-1:0];
          law_pkg::REG_BOUND_Y:      bound_y      <= pwdata[law_pkg::BOUND_W-1:0];
          law_pkg::REG_START_EDGE_X: start_edge_x <= pwdata[law_pkg::BOUND_W-1:0];
          law_pkg::REG_START_EDGE_Y: start_edge_y <= pwdata[law_pkg::BOUND_W-1:0];
          law_pkg::REG_MAX_STEPS:    max_steps    <= pwdata[law_pkg::STEPS_W-1:0];
          default: ;
        endcase
      end
      if (go_search) begin
        iss <= CNT_W'(2);
      end else if ((state == law_pkg::S_SEARCH) && !resolve) begin
        iss <= iss + CNT_W'(1);
      end
      if (commit) begin
        walker_px     <= px_n;
        walker_py     <= py_n;
        steps_taken   <= steps_n;
        walker_live   <= live_n;
        cluster_count <= count_n;
        out_valid     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      lat_cmd <= in_ch.cmd;
      lat_sx  <= in_ch.start_x;
      lat_sy  <= in_ch.start_y;
      lat_dx  <= in_ch.step_x;
      lat_dy  <= in_ch.step_y;
    end
    if (commit) begin
      out_status <= res_status;
      out_x      <= res_x[ICW-1:0];
      out_y      <= res_y[ICW-1:0];
      out_size   <= count_wide[law_pkg::SIZE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/law_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds when no read is issued. No dependencies.
`default_nettype none

module law_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
